// ----- hdl/efd_pkg.sv -----
// efd_pkg: shared types and constants of the eased brightness fader
// beat structs, action and curve codes, shared arithmetic unit opcodes
// no dependencies
`timescale 1ns / 1ps

package efd_pkg;

  // action codes of an input beat
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  // easing curve codes
  localparam logic [1:0] CURVE_LINEAR   = 2'd0;
  localparam logic [1:0] CURVE_EASE_IN  = 2'd1;
  localparam logic [1:0] CURVE_EASE_OUT = 2'd2;
  localparam logic [1:0] CURVE_SMOOTH   = 2'd3;

  // register index decoded from the config address
  localparam logic REG_EASING = 1'b0;

  // level and phase constants
  localparam logic [7:0]  LEVEL_MAX   = 8'd100;
  localparam logic [16:0] PHASE_ONE   = 17'd65536;
  localparam logic [16:0] PHASE_TOP   = 17'd65535;

  // ceil(2^30 / 100): exact divide by 100 for any span times level step
  localparam logic [23:0] DUR_RECIP   = 24'd10737419;

  // shared unit sizes
  localparam int MUL_STEPS = 17;
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  target_percent;
    logic [15:0] fade_time_ms;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] level;
    logic       fading;
    logic       level_changed;
    logic       fade_done;
  } out_beat_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_ctrl_t;

endpackage

// ----- hdl/efd_alu.sv -----
// efd_alu: shared serial arithmetic unit, one bit per cycle
// shift-add multiply (17 x 17) and restoring divide (32 / 16)
// depends on efd_pkg
`timescale 1ns / 1ps

module efd_alu
  import efd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  alu_ctrl_t   ctrl,
  input  logic [31:0] opa,
  input  logic [16:0] opb,
  output logic        done,
  output logic [33:0] result
);

  logic        busy;
  alu_op_t     op_r;
  logic [4:0]  cnt;
  logic [33:0] acc;
  logic [33:0] mcand;
  logic [16:0] mplier;
  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] divisor;
  logic [16:0] shifted;
  logic [17:0] trial;

  // divide trial subtraction
  assign shifted = {rem, quo[31]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.go) begin
        busy    <= 1'b1;
        op_r    <= ctrl.op;
        cnt     <= (ctrl.op == ALU_MUL) ? 5'(MUL_STEPS - 1) : 5'(DIV_STEPS - 1);
        acc     <= '0;
        mcand   <= {17'd0, opa[16:0]};
        mplier  <= opb;
        quo     <= opa;
        rem     <= '0;
        divisor <= opb[15:0];
      end else if (busy) begin
        case (op_r)
          ALU_MUL: begin
            if (mplier[0]) begin
              acc <= acc + mcand;
            end
            mcand  <= {mcand[32:0], 1'b0};
            mplier <= {1'b0, mplier[16:1]};
          end
          ALU_DIV: begin
            if (!trial[17]) begin
              rem <= trial[15:0];
              quo <= {quo[30:0], 1'b1};
            end else begin
              rem <= shifted[15:0];
              quo <= {quo[30:0], 1'b0};
            end
          end
          default: begin
            acc <= acc;
          end
        endcase
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign result = (op_r == ALU_DIV) ? {2'b00, quo} : acc;

endmodule

// ----- hdl/eased_brightness_fader_top.sv -----
// eased_brightness_fader_top: lamp level fader with selectable easing curve
// sequencer, fade state, config register and output register
// depends on efd_pkg and efd_alu
`timescale 1ns / 1ps
// sequence: cancel and unused beats, zero-span starts, idle and ending ticks go straight to
// the output register; a start with a nonzero span runs a 17-step multiply (reciprocal
// divide by 100); a fading tick runs a 32-step phase divide, then one to three 17-step
// multiplies by curve; a stalled output holds the next result in ST_OUT
// throughput: one beat at a time, the next beat is taken the cycle after the result is
// registered; the serial multiply/divide unit serves each step in turn
// reset: synchronous, clears all fade state and the curve register at once

module eased_brightness_fader_top
  import efd_pkg::*;
#(
  parameter int TICK_MS     = 10,
  parameter int MIN_FADE_MS = 50
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUR_MUL,
    ST_PH_DIV,
    ST_SQ_MUL,
    ST_CU_MUL,
    ST_INT_MUL,
    ST_OUT
  } state_t;

  state_t      state;
  logic [1:0]  easing;
  logic [6:0]  current_level;
  logic [6:0]  target_level;
  logic [6:0]  start_level;
  logic [15:0] fade_length_ms;
  logic [15:0] elapsed_ms;
  logic        fade_active;
  logic [6:0]  before_level;
  logic        done_flag;
  logic [16:0] phase;
  logic [15:0] sq;
  logic [6:0]  diff;

  alu_ctrl_t   alu_ctrl;
  logic [31:0] alu_a;
  logic [16:0] alu_b;
  logic        alu_done;
  logic [33:0] alu_result;

  logic        accept;
  logic [6:0]  tgt_sat;
  logic [6:0]  start_diff;
  logic [16:0] e_sum;
  logic [15:0] e_clamp;
  logic        launch_int;
  logic [16:0] shaped;
  logic [17:0] smooth;
  logic [6:0]  hi;
  logic [6:0]  lvl;
  logic [46:0] dur_prod;
  logic [15:0] dur_q;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EASING) ? {30'd0, easing} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      easing <= CURVE_LINEAR;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EASING)) begin
      easing <= pwdata[1:0];
    end
  end

  // start decode
  assign tgt_sat    = (in_beat.target_percent > LEVEL_MAX) ? LEVEL_MAX[6:0]
                                                           : in_beat.target_percent[6:0];
  assign start_diff = (tgt_sat > current_level) ? tgt_sat - current_level
                                                : current_level - tgt_sat;

  // scaled duration divided by 100 through a reciprocal multiply
  assign dur_prod = {24'd0, alu_result[22:0]} * {23'd0, DUR_RECIP};
  assign dur_q    = dur_prod[45:30];

  // elapsed time advance, clamped to the fade length
  assign e_sum   = {1'b0, elapsed_ms} + 17'(TICK_MS);
  assign e_clamp = (e_sum >= {1'b0, fade_length_ms}) ? fade_length_ms : e_sum[15:0];

  // curve shaping: decides when the interpolation multiply can start
  assign smooth = 18'(3) * {2'b00, sq} - {1'b0, alu_result[31:16], 1'b0};

  always_comb begin
    launch_int = 1'b0;
    shaped     = phase;
    case (state)
      ST_PH_DIV: begin
        if (alu_result[16:0] == 17'd0) begin
          launch_int = alu_done;
          shaped     = 17'd0;
        end else if (alu_result[16:0] >= PHASE_TOP) begin
          launch_int = alu_done;
          shaped     = PHASE_TOP;
        end else if (easing == CURVE_LINEAR) begin
          launch_int = alu_done;
          shaped     = alu_result[16:0];
        end
      end
      ST_SQ_MUL: begin
        if (easing == CURVE_EASE_IN) begin
          launch_int = alu_done;
          shaped     = {1'b0, alu_result[31:16]};
        end else if (easing == CURVE_EASE_OUT) begin
          launch_int = alu_done;
          shaped     = PHASE_TOP - {1'b0, alu_result[31:16]};
        end else if (easing != CURVE_SMOOTH) begin
          launch_int = alu_done;
          shaped     = phase;
        end
      end
      ST_CU_MUL: begin
        launch_int = alu_done;
        shaped     = (smooth > {1'b0, PHASE_ONE}) ? PHASE_ONE : smooth[16:0];
      end
      default: begin
        launch_int = 1'b0;
      end
    endcase
  end

  // interpolation from the latched start level
  assign hi  = alu_result[22:16];
  assign lvl = (target_level >= start_level) ? start_level + hi
             : start_level - hi - 7'(alu_result[15:0] != 16'd0);

  efd_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_result)
  );

  // sequencer, fade state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      current_level  <= '0;
      target_level   <= '0;
      start_level    <= '0;
      fade_length_ms <= '0;
      elapsed_ms     <= '0;
      fade_active    <= 1'b0;
      out_valid      <= 1'b0;
      alu_ctrl       <= '{go: 1'b0, op: ALU_MUL};
    end else begin
      // go is a one-cycle pulse; no new launch can happen while it is high
      if (alu_ctrl.go) begin
        alu_ctrl.go <= 1'b0;
      end
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      if (launch_int) begin
        alu_ctrl <= '{go: 1'b1, op: ALU_MUL};
        alu_a    <= {15'd0, shaped};
        alu_b    <= {10'd0, diff};
        state    <= ST_INT_MUL;
      end else begin
        case (state)
          ST_IDLE: begin
            if (accept) begin
              before_level <= current_level;
              done_flag    <= 1'b0;
              state        <= ST_OUT;
              case (in_beat.action)
                ACT_START: begin
                  target_level <= tgt_sat;
                  start_level  <= current_level;
                  elapsed_ms   <= '0;
                  fade_active  <= 1'b1;
                  diff         <= start_diff;
                  if (in_beat.fade_time_ms == 16'd0) begin
                    fade_length_ms <= '0;
                  end else begin
                    alu_ctrl <= '{go: 1'b1, op: ALU_MUL};
                    alu_a    <= {16'd0, in_beat.fade_time_ms};
                    alu_b    <= {10'd0, start_diff};
                    state    <= ST_DUR_MUL;
                  end
                end
                ACT_CANCEL: begin
                  fade_active <= 1'b0;
                end
                ACT_TICK: begin
                  if (fade_active) begin
                    if (current_level == target_level || fade_length_ms == 16'd0) begin
                      current_level <= target_level;
                      start_level   <= target_level;
                      fade_active   <= 1'b0;
                      elapsed_ms    <= '0;
                      done_flag     <= 1'b1;
                    end else begin
                      elapsed_ms <= e_clamp;
                      diff       <= (target_level >= start_level)
                                    ? target_level - start_level
                                    : start_level - target_level;
                      alu_ctrl   <= '{go: 1'b1, op: ALU_DIV};
                      alu_a      <= {e_clamp, 16'd0};
                      alu_b      <= {1'b0, fade_length_ms};
                      state      <= ST_PH_DIV;
                    end
                  end
                end
                default: begin
                  done_flag <= 1'b0;
                end
              endcase
            end
          end
          ST_DUR_MUL: begin
            if (alu_done) begin
              if (dur_q < 16'(MIN_FADE_MS) && diff != 7'd0) begin
                fade_length_ms <= 16'(MIN_FADE_MS);
              end else begin
                fade_length_ms <= dur_q;
              end
              state <= ST_OUT;
            end
          end
          ST_PH_DIV: begin
            if (alu_done) begin
              phase    <= alu_result[16:0];
              alu_ctrl <= '{go: 1'b1, op: ALU_MUL};
              if (easing == CURVE_EASE_OUT) begin
                alu_a <= {15'd0, PHASE_TOP - alu_result[16:0]};
                alu_b <= PHASE_TOP - alu_result[16:0];
              end else begin
                alu_a <= {15'd0, alu_result[16:0]};
                alu_b <= alu_result[16:0];
              end
              state <= ST_SQ_MUL;
            end
          end
          ST_SQ_MUL: begin
            if (alu_done) begin
              sq       <= alu_result[31:16];
              alu_ctrl <= '{go: 1'b1, op: ALU_MUL};
              alu_a    <= {16'd0, alu_result[31:16]};
              alu_b    <= phase;
              state    <= ST_CU_MUL;
            end
          end
          ST_CU_MUL: begin
            state <= ST_CU_MUL;
          end
          ST_INT_MUL: begin
            if (alu_done) begin
              if (elapsed_ms >= fade_length_ms) begin
                current_level <= target_level;
                start_level   <= target_level;
                fade_active   <= 1'b0;
                elapsed_ms    <= '0;
                done_flag     <= 1'b1;
              end else begin
                current_level <= lvl;
              end
              state <= ST_OUT;
            end
          end
          ST_OUT: begin
            if (!out_valid || !out_stall) begin
              out_valid              <= 1'b1;
              out_beat.level         <= current_level;
              out_beat.fading        <= fade_active;
              out_beat.level_changed <= (current_level != before_level);
              out_beat.fade_done     <= done_flag;
              state                  <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  // the level never leaves the percent range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_beat.level <= LEVEL_MAX[6:0]))
    else $error("output level above full scale");

  // a completed fade is never reported as still fading
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.fade_done) |-> !out_beat.fading)
    else $error("fade done while still fading");

  // an accepted beat keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken before the first finished");

  // the shared unit is only started while an item is in work
  a_alu_busy: assert property (@(posedge clk) disable iff (rst)
    alu_ctrl.go |-> (state != ST_IDLE && state != ST_OUT))
    else $error("arithmetic unit started outside a sequence");

endmodule

// ----- tb/sv/efd_fade_checker.sv -----
// efd_fade_checker: watches the beat and config channels of the eased brightness fader,
// predicts each result beat and compares it field by field
// depends on efd_pkg
`timescale 1ns / 1ps

module efd_fade_checker
  import efd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_beat,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);

  localparam int TICK_MS     = 10;
  localparam int MIN_FADE_MS = 50;
  localparam logic [2:0] EASING_ADDR = {REG_EASING, 2'b00};

  // predicted fade state and curve register
  logic [1:0]  curve_sel;
  logic [6:0]  lvl_now;
  logic [6:0]  lvl_goal;
  logic [6:0]  lvl_origin;
  logic [15:0] span_ms;
  logic [15:0] spent_ms;
  logic        fade_on;

  // predicted result beats, oldest first
  out_beat_t predicted_levels[$];
  int        results_seen;

  // one line per mismatch, always counted
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s = %0d, predicted %0d",
                                results_seen, name, got, want));
  endtask

  // shape a Q16 phase with the selected curve
  function automatic longint unsigned ease_phase(input logic [1:0] curve,
                                                 input longint unsigned t);
    longint unsigned a, sq, cu;
    if (t == 0) return 0;
    if (t >= 65535) return 65535;
    case (curve)
      CURVE_EASE_IN: return (t * t) >> 16;
      CURVE_EASE_OUT: begin
        a = 65535 - t;
        return 65535 - ((a * a) >> 16);
      end
      CURVE_SMOOTH: begin
        sq = (t * t) >> 16;
        cu = (sq * t) >> 16;
        return 3 * sq - 2 * cu;
      end
      default: return t;
    endcase
  endfunction

  // land on the target and go idle
  task automatic finish_fade();
    lvl_now    = lvl_goal;
    fade_on    = 1'b0;
    lvl_origin = lvl_goal;
    spent_ms   = '0;
  endtask

  // advance the predicted state by one input beat
  task automatic predict_fade_step(input in_beat_t b, output out_beat_t r);
    logic [6:0]      lvl_before;
    logic            done;
    longint unsigned goal, diff, dur, e, ph, val;
    lvl_before = lvl_now;
    done = 1'b0;
    case (b.action)
      ACT_START: begin
        goal = 64'((b.target_percent > LEVEL_MAX) ? LEVEL_MAX : b.target_percent);
        diff = (goal > lvl_now) ? goal - lvl_now : lvl_now - goal;
        dur = (64'(b.fade_time_ms) * diff) / 100;
        if (dur < MIN_FADE_MS && diff > 0 && b.fade_time_ms != 0) dur = MIN_FADE_MS;
        if (b.fade_time_ms == 0) dur = 0;
        lvl_goal   = goal[6:0];
        span_ms    = dur[15:0];
        lvl_origin = lvl_now;
        spent_ms   = '0;
        fade_on    = 1'b1;
      end
      ACT_CANCEL: fade_on = 1'b0;
      ACT_TICK: if (fade_on) begin
        if (lvl_now == lvl_goal || span_ms == 0) begin
          finish_fade();
          done = 1'b1;
        end else begin
          e = 64'(spent_ms) + TICK_MS;
          if (e >= span_ms) e = 64'(span_ms);
          spent_ms = e[15:0];
          ph = (e << 16) / span_ms;
          ph = ease_phase(curve_sel, ph);
          if (ph > 65536) ph = 65536;
          if (lvl_goal >= lvl_origin)
            val = (64'(lvl_origin) << 16) + 64'(lvl_goal - lvl_origin) * ph;
          else
            val = (64'(lvl_origin) << 16) - 64'(lvl_origin - lvl_goal) * ph;
          lvl_now = val[22:16];
          if (spent_ms >= span_ms) begin
            finish_fade();
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.level         = lvl_now;
    r.fading        = fade_on;
    r.level_changed = (lvl_now != lvl_before);
    r.fade_done     = done;
  endtask

  // config writes, result beats, then input beats
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      curve_sel    = CURVE_LINEAR;
      lvl_now      = '0;
      lvl_goal     = '0;
      lvl_origin   = '0;
      span_ms      = '0;
      spent_ms     = '0;
      fade_on      = 1'b0;
      results_seen = 0;
      predicted_levels.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == EASING_ADDR)
        curve_sel = pwdata[1:0];
      if (out_valid && !out_stall) begin
        if (predicted_levels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing predicted", results_seen));
        end else begin
          want = predicted_levels.pop_front();
          check_field("level", out_beat.level, want.level);
          check_field("fading", 7'(out_beat.fading), 7'(want.fading));
          check_field("level_changed", 7'(out_beat.level_changed), 7'(want.level_changed));
          check_field("fade_done", 7'(out_beat.fade_done), 7'(want.fade_done));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        predict_fade_step(in_beat, want);
        predicted_levels.push_back(want);
      end
    end
    outstanding = predicted_levels.size();
  end

endmodule

// ----- tb/sv/tb_eased_brightness_fader_top.sv -----
// tb_eased_brightness_fader_top: stimulus and verdict for the eased brightness fader
// drives directed and random beats under several idle mixes, checking is in efd_fade_checker
// depends on efd_pkg, eased_brightness_fader_top and efd_fade_checker
`timescale 1ns / 1ps

module tb_eased_brightness_fader_top;
  import efd_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int RUN_LIMIT_NS  = 20_000_000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 115;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [2:0] EASING_ADDR = {REG_EASING, 2'b00};

  // idle mixes: none, sender idle, receiver stall, both
  localparam int SEND_IDLE[4]  = '{0, 77, 0, 13};
  localparam int RECV_STALL[4] = '{0, 0, 77, 13};
  localparam logic [1:0] CURVE_ORDER[PHASES] = '{CURVE_EASE_IN, CURVE_EASE_OUT, CURVE_SMOOTH,
                                                 CURVE_LINEAR, CURVE_SMOOTH, CURVE_LINEAR,
                                                 CURVE_EASE_OUT, CURVE_EASE_IN};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_beat;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_beat;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int outstanding;
  int beats_sent;
  int send_idle_pct;
  int stall_pct;

  eased_brightness_fader_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  efd_fade_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("eased_brightness_fader_top test failed");
    $finish;
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [1:0] act, input logic [7:0] pct, input logic [15:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{action: act, target_percent: pct, fade_time_ms: ms};
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_beat(ACT_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)));
  endtask

  // hold the sender until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access cycle of a config write
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // curve change only once the fader is idle; upper bits are don't-care noise
  task automatic set_curve(input logic [1:0] curve);
    logic [31:0] word;
    word = $urandom;
    word[1:0] = curve;
    drain();
    apb_write(EASING_ADDR, word);
  endtask

  // half in range, half anywhere in the field (saturating)
  function automatic logic [7:0] pick_target();
    return $urandom_range(1) ? 8'($urandom_range(100)) : 8'($urandom_range(255));
  endfunction

  // a start followed by ticks, with the odd cancel or restart mixed in
  task automatic run_fade();
    int span;
    int n;
    int pick;
    span = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(400);
    send_beat(ACT_START, pick_target(), 16'(span));
    n = $urandom_range(1, 45);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 3)
        send_beat(ACT_CANCEL, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      else if (pick < 6)
        send_beat(ACT_START, pick_target(), 16'($urandom_range(400)));
      else
        send_ticks(1);
    end
  endtask

  initial begin
    int phase_end;
    bit held;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    beats_sent    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats, linear curve
    set_curve(CURVE_LINEAR);
    send_beat(ACT_TICK, 8'd255, 16'hFFFF);     // tick while idle
    send_beat(ACT_UNUSED, 8'd0, 16'd0);         // unused action code
    send_beat(ACT_CANCEL, 8'd100, 16'd1);       // cancel while idle
    send_beat(ACT_START, 8'd255, 16'hFFFF);     // saturated target, longest span
    send_ticks(1);
    send_beat(ACT_START, 8'd101, 16'd1);        // restart mid-fade, duration floored
    send_ticks(5);
    send_beat(ACT_START, 8'd0, 16'd0);          // zero duration
    send_ticks(1);
    send_beat(ACT_START, 8'd0, 16'd500);        // already at target
    send_ticks(1);
    send_beat(ACT_START, 8'd37, 16'd200);
    send_ticks(2);
    send_beat(ACT_CANCEL, 8'd0, 16'd0);         // cancel keeps the level
    send_ticks(1);
    send_beat(ACT_START, 8'd100, 16'd1000);     // start from the kept level
    send_ticks(2);
    send_beat(ACT_START, 8'd0, 16'd300);        // reverse direction mid-fade
    send_ticks(2);

    // random phases, one curve and idle mix each
    for (int p = 0; p < PHASES; p++) begin
      set_curve(CURVE_ORDER[p]);
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct     = RECV_STALL[p % 4];
      phase_end = beats_sent + PHASE_ITEMS;
      held = 1'b0;
      while (beats_sent < phase_end) begin
        // pause halfway until the pipeline is empty
        if (!held && beats_sent >= phase_end - PHASE_ITEMS / 2) begin
          drain();
          held = 1'b1;
        end
        if ($urandom_range(99) < 75)
          run_fade();
        else
          send_beat(2'($urandom_range(3)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("eased_brightness_fader_top test passed");
    end else begin
      $display("eased_brightness_fader_top test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/efd_pkg.sv
hdl/efd_alu.sv
hdl/eased_brightness_fader_top.sv
tb/sv/efd_fade_checker.sv
tb/sv/tb_eased_brightness_fader_top.sv
